// ----- rtl/rpn_pkg.sv -----
// Shared constants, codes and command/status types of the RPN evaluator.
`timescale 1ns / 1ps
package rpn_pkg;

   localparam int STACK_DEPTH = 256;
   localparam int DATA_W      = 32;
   localparam int CHAR_W      = 8;
   localparam int STATUS_W    = 3;
   localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   // character codes
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_LEFTOVER  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd3;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 3'd5;
   localparam logic [STATUS_W-1:0] ST_DIVZERO   = 3'd6;

   typedef struct packed {
      logic load_char;   // capture the accepted beat
      logic acc_step;    // fold a digit into the accumulator
      logic push_acc;    // push the pending number
      logic op_check;    // flag checks and fetch the second operand
      logic op_write;    // replace the top two entries with the result
      logic div_start;   // kick off the divider
      logic rsp_load;    // load the result register and clear for next expr
   } cmd_type;

   typedef struct packed {
      logic is_digit;
      logic is_space;
      logic is_div;
      logic in_number;
      logic last;
      logic depth_lt2;
      logic b_zero;
      logic div_busy;
   } stat_type;

endpackage

// ----- rtl/rpn_if.sv -----
// Valid/ready channel interfaces for characters in and results out.
`timescale 1ns / 1ps
interface rpn_req_if import rpn_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              end_of_expr;

   modport source (output valid, output char_code, output end_of_expr, input ready);
   modport sink   (input valid, input char_code, input end_of_expr, output ready);
endinterface

interface rpn_rsp_if import rpn_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [DATA_W-1:0]   value;
   logic        [STATUS_W-1:0] status;

   modport source (output valid, output value, output status, input ready);
   modport sink   (input valid, input value, input status, output ready);
endinterface

// ----- rtl/rpn_stack_evaluator.sv -----
// Top level of the RPN stack evaluator: controller, datapath and channel hookup.
`timescale 1ns / 1ps
// Usage:
//   req_if carries one ASCII character per beat plus end_of_expr on the last
//   character of an expression. rsp_if carries one beat per expression: the
//   bottom stack value (0 if empty) and a status code (first error kept).
//   Steps per character, from acceptance until req_if.ready returns:
//     digit or whitespace: capture, decode
//     + - * or unknown:    capture, decode, stack read, execute;
//                          capture, decode, check with fewer than two values stacked
//     /:                   as above, plus the divider run when the divisor is nonzero
//     pending number ends on an operator: no extra step, push is in decode
//   The last character adds a flush step when it is a digit, and a result step
//   to load the result register; the result appears the cycle after that.
//   Stack access is one write port and one registered read port; the top
//   entry and the bottom entry are held in registers.
//   Reset (synchronous, active high) empties the stack and clears the
//   accumulator and error state at once; the stack memory is not cleared.
//   A stalled receiver holds the result in the output register while the
//   block keeps taking characters; it only waits when the next result is due.
module rpn_stack_evaluator import rpn_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   rpn_req_if.sink   req_if,
   rpn_rsp_if.source rsp_if
);

   cmd_type  cmd;
   stat_type status;

   rpn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rpn_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_char   (req_if.char_code),
      .req_last   (req_if.end_of_expr),
      .rsp_value  (rsp_if.value),
      .rsp_status (rsp_if.status)
   );

endmodule

// ----- rtl/rpn_div.sv -----
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
module rpn_div import rpn_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] dividend,
   input  logic [DATA_W-1:0] divisor,
   output logic              busy,
   output logic [DATA_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DATA_W + 1);

   logic              busy_ff, busy_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] dvs_ff, dvs_in;
   logic              neg_ff, neg_in;
   logic [DATA_W:0]   rem_sh;
   logic [DATA_W:0]   trial;

   assign rem_sh = {rem_ff, quo_ff[DATA_W-1]};
   assign trial  = rem_sh - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DATA_W);
         rem_in  = '0;
         // work on magnitudes, fix the sign at the end
         quo_in  = dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
         dvs_in  = divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
         neg_in  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
      end else if (busy_ff) begin
         if (!trial[DATA_W]) begin
            rem_in = trial[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign busy     = busy_ff;
   assign quotient = neg_ff ? (DATA_W'(0) - quo_ff) : quo_ff;

endmodule

// ----- rtl/rpn_dp.sv -----
// Datapath: character decode, number accumulator, operand stack, ALU and result register.
`timescale 1ns / 1ps
module rpn_dp import rpn_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   output stat_type                   status,
   input  logic [CHAR_W-1:0]          req_char,
   input  logic                       req_last,
   output logic signed [DATA_W-1:0]   rsp_value,
   output logic        [STATUS_W-1:0] rsp_status
);

   // Top of stack sits in tos_ff; entries below it live in the memory.
   // bot_ff mirrors entry 0 so the result needs no extra read.
   logic [DATA_W-1:0]   stack_mem [STACK_DEPTH];
   logic [DATA_W-1:0]   rdata_ff;
   logic [DATA_W-1:0]   tos_ff;
   logic [DATA_W-1:0]   bot_ff;
   logic [CHAR_W-1:0]   char_ff;
   logic                last_ff;
   logic signed [DATA_W-1:0]   value_ff;
   logic        [STATUS_W-1:0] status_ff;

   logic [DEPTH_W-1:0]  depth_ff, depth_in;
   logic [DATA_W-1:0]   acc_ff, acc_in;
   logic                in_num_ff, in_num_in;
   logic [STATUS_W-1:0] err_ff, err_in;

   logic                is_digit, is_space, is_known, is_div;
   logic                full, depth_lt2;
   logic                mem_we, mem_re;
   logic [ADDR_W-1:0]   waddr, raddr;
   logic [DEPTH_W-1:0]  depth_m1, depth_m2;
   logic [DATA_W-1:0]   digit;
   logic [DATA_W-1:0]   alu_res;
   logic [DATA_W-1:0]   quotient;
   logic                div_busy;
   logic                flag_v;
   logic [STATUS_W-1:0] flag_code;
   logic [STATUS_W-1:0] final_status;

   assign is_digit  = (char_ff >= CH_ZERO) && (char_ff <= CH_NINE);
   assign is_space  = ((char_ff >= CH_TAB) && (char_ff <= CH_CR)) || (char_ff == CH_SPACE);
   assign is_div    = (char_ff == CH_SLASH);
   assign is_known  = (char_ff == CH_PLUS) || (char_ff == CH_MINUS) ||
                      (char_ff == CH_STAR) || is_div;
   assign full      = (depth_ff == DEPTH_W'(STACK_DEPTH));
   assign depth_lt2 = (depth_ff < DEPTH_W'(2));
   assign depth_m1  = depth_ff - DEPTH_W'(1);
   assign depth_m2  = depth_ff - DEPTH_W'(2);
   assign waddr     = depth_m1[ADDR_W-1:0];
   assign raddr     = depth_m2[ADDR_W-1:0];
   assign mem_we    = cmd.push_acc && !full && (depth_ff != '0);
   assign mem_re    = cmd.op_check && !depth_lt2;
   assign digit     = DATA_W'(char_ff - CH_ZERO);

   rpn_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (rdata_ff),
      .divisor  (tos_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   // a = rdata_ff (lower), b = tos_ff (top)
   always_comb begin
      unique case (char_ff)
         CH_PLUS:  alu_res = rdata_ff + tos_ff;
         CH_MINUS: alu_res = rdata_ff - tos_ff;
         CH_STAR:  alu_res = rdata_ff * tos_ff;
         CH_SLASH: alu_res = (tos_ff == '0) ? '0 : quotient;
         default:  alu_res = '0;
      endcase
   end

   always_comb begin
      flag_v    = 1'b0;
      flag_code = ST_OK;
      priority if (cmd.push_acc && full) begin
         flag_v    = 1'b1;
         flag_code = ST_OVERFLOW;
      end else if (cmd.op_check && !is_known) begin
         flag_v    = 1'b1;
         flag_code = ST_UNKNOWN;
      end else if (cmd.op_check && depth_lt2) begin
         flag_v    = 1'b1;
         flag_code = ST_UNDERFLOW;
      end else if (cmd.op_write && is_div && (tos_ff == '0)) begin
         flag_v    = 1'b1;
         flag_code = ST_DIVZERO;
      end else begin
         flag_v    = 1'b0;
      end
   end

   always_comb begin
      depth_in  = depth_ff;
      acc_in    = acc_ff;
      in_num_in = in_num_ff;
      err_in    = err_ff;
      if (flag_v && (err_ff == ST_OK)) begin
         err_in = flag_code;
      end
      if (cmd.acc_step) begin
         acc_in    = (acc_ff << 3) + (acc_ff << 1) + digit;
         in_num_in = 1'b1;
      end
      if (cmd.push_acc) begin
         acc_in    = '0;
         in_num_in = 1'b0;
         if (!full) begin
            depth_in = depth_ff + DEPTH_W'(1);
         end
      end
      if (cmd.op_write) begin
         depth_in = depth_m1;
      end
      if (cmd.rsp_load) begin
         depth_in  = '0;
         acc_in    = '0;
         in_num_in = 1'b0;
         err_in    = ST_OK;
      end
   end

   always_comb begin
      priority if (err_ff != ST_OK) begin
         final_status = err_ff;
      end else if (depth_ff == '0) begin
         final_status = ST_EMPTY;
      end else if (depth_ff > DEPTH_W'(1)) begin
         final_status = ST_LEFTOVER;
      end else begin
         final_status = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff  <= '0;
         acc_ff    <= '0;
         in_num_ff <= 1'b0;
         err_ff    <= ST_OK;
      end else begin
         depth_ff  <= depth_in;
         acc_ff    <= acc_in;
         in_num_ff <= in_num_in;
         err_ff    <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_char) begin
         char_ff <= req_char;
         last_ff <= req_last;
      end
      if (cmd.push_acc && !full) begin
         tos_ff <= acc_ff;
         if (depth_ff == '0) begin
            bot_ff <= acc_ff;
         end
      end
      if (cmd.op_write) begin
         tos_ff <= alu_res;
         if (depth_ff == DEPTH_W'(2)) begin
            bot_ff <= alu_res;
         end
      end
      if (cmd.rsp_load) begin
         value_ff  <= (depth_ff != '0) ? $signed(bot_ff) : '0;
         status_ff <= final_status;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[waddr] <= tos_ff;
      end
      if (mem_re) begin
         rdata_ff <= stack_mem[raddr];
      end
   end

   assign status.is_digit  = is_digit;
   assign status.is_space  = is_space;
   assign status.is_div    = is_div;
   assign status.in_number = in_num_ff;
   assign status.last      = last_ff;
   assign status.depth_lt2 = depth_lt2;
   assign status.b_zero    = (tos_ff == '0);
   assign status.div_busy  = div_busy;

   assign rsp_value  = value_ff;
   assign rsp_status = status_ff;

endmodule

// ----- rtl/rpn_ctrl.sv -----
// Controller: sequences decode, push and operator steps for each beat, and the result step per expression.
`timescale 1ns / 1ps
module rpn_ctrl import rpn_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type status,
   output cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_FLUSH,
      S_OPER,
      S_EXEC,
      S_DIV,
      S_RESULT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.load_char = req_valid;
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (status.is_digit) begin
               cmd.acc_step = 1'b1;
               state_in     = status.last ? S_FLUSH : S_IDLE;
            end else begin
               cmd.push_acc = status.in_number;
               if (!status.is_space) begin
                  state_in = S_OPER;
               end else begin
                  state_in = status.last ? S_RESULT : S_IDLE;
               end
            end
         end
         S_FLUSH: begin
            cmd.push_acc = 1'b1;
            state_in     = S_RESULT;
         end
         S_OPER: begin
            cmd.op_check = 1'b1;
            if (status.depth_lt2) begin
               state_in = status.last ? S_RESULT : S_IDLE;
            end else begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (status.is_div && !status.b_zero) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else begin
               cmd.op_write = 1'b1;
               state_in     = status.last ? S_RESULT : S_IDLE;
            end
         end
         S_DIV: begin
            if (!status.div_busy) begin
               cmd.op_write = 1'b1;
               state_in     = status.last ? S_RESULT : S_IDLE;
            end
         end
         S_RESULT: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // a pending result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while still pending");

   // no new beat is taken while a division is running
   a_idle_div: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !status.div_busy)
      else $error("input accepted with divider busy");

   a_div_runs: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> (state_ff == S_DIV) && status.div_busy)
      else $error("divider did not start");

   // an operator only writes back with two operands present
   a_write_depth: assert property (@(posedge clock) disable iff (reset)
      cmd.op_write |-> !status.depth_lt2)
      else $error("operator write-back with fewer than two operands");

endmodule
